[sv/multi_digit_seven_segment_driver_assert.svh]
// Assertion macros for the seven-segment driver
`ifndef MULTI_DIGIT_SEVEN_SEGMENT_DRIVER_ASSERT_SVH
`define MULTI_DIGIT_SEVEN_SEGMENT_DRIVER_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define MDSS_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// post must hold in the cycle after pre
`define MDSS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle check");

`endif

[sv/mdss_pkg.sv]
// Shared types, codes and segment decode for the seven-segment driver
package mdss_pkg;

    localparam int MAX_DIGITS = 4;
    localparam int SEG_W      = 8;
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic OP_DIGIT  = 1'b0;
    localparam logic OP_NUMBER = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  digit_index;
        logic [15:0] value;
    } mdss_req_t;

    typedef struct packed {
        logic [1:0]                   status;
        logic [MAX_DIGITS*SEG_W-1:0]  pin_levels;
    } mdss_rsp_t;

    typedef enum logic [1:0] {
        CMD_DIGIT  = 2'd0,
        CMD_NUMBER = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                       kind;
        logic [1:0]                      status;
        logic [$clog2(MAX_DIGITS)-1:0]   idx;
        logic [15:0]                     value;
    } mdss_cmd_t;

    function automatic int pow10(input int n);
        int r;
        r = 1;
        for (int i = 0; i < n; i++)
        begin
            r = r * 10;
        end
        return r;
    endfunction

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

[sv/mdss_cmdq.sv]
// Two-entry command queue between front end and back end
module mdss_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  mdss_pkg::mdss_cmd_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output mdss_pkg::mdss_cmd_t rd_data,
    output logic              empty
);
    import mdss_pkg::*;

    mdss_cmd_t        entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/mdss_front.sv]
// Front end: takes requests, range-checks them and classifies them into commands
module mdss_front #(
    parameter int DIGITS = 4
) (
    input  logic                push,
    output logic                full,
    input  mdss_pkg::mdss_req_t req,
    input  logic                q_full,
    output logic                enq,
    output mdss_pkg::mdss_cmd_t cmd
);
    import mdss_pkg::*;

    localparam logic [15:0] NUM_LIMIT = 16'(pow10(DIGITS) - 1);
    localparam int          IW        = $clog2(MAX_DIGITS);

    assign full = q_full;
    assign enq  = push && !q_full;

    always_comb
    begin
        cmd.kind   = CMD_REJECT;
        cmd.status = ST_OK;
        cmd.idx    = req.digit_index[IW-1:0];
        cmd.value  = req.value;
        if (req.opcode == OP_DIGIT)
        begin
            if (req.digit_index >= 8'(DIGITS))
            begin
                cmd.status = ST_INDEX;
            end
            else if (req.value > 16'd9)
            begin
                cmd.status = ST_RANGE;
            end
            else
            begin
                cmd.kind = CMD_DIGIT;
            end
        end
        else
        begin
            if (req.value > NUM_LIMIT)
            begin
                cmd.status = ST_RANGE;
            end
            else
            begin
                cmd.kind = CMD_NUMBER;
            end
        end
    end

endmodule

[sv/mdss_back.sv]
// Back end: updates digit patterns one decimal digit per cycle and emits pin levels
module mdss_back #(
    parameter int DIGITS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mdss_pkg::mdss_cmd_t                cmd,
    input  logic                               cmd_valid,
    output logic                               cmd_pop,
    input  logic [mdss_pkg::MAX_DIGITS-1:0]    anode_mask,
    output mdss_pkg::mdss_rsp_t                rsp,
    output logic                               empty,
    input  logic                               pop
);
    import mdss_pkg::*;

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [SEG_W-1:0]   pat_reg [MAX_DIGITS];
    logic [SEG_W-1:0]   pat_next [MAX_DIGITS];
    logic [15:0]        rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [1:0]         status_reg, status_next;
    mdss_rsp_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [31:0]        prod;
    logic [15:0]        quot;
    logic [15:0]        rmd;
    logic               conv_done;
    logic               out_free;
    logic [MAX_DIGITS*SEG_W-1:0] pin_word;

    // divide by 10 via reciprocal multiply, exact for 16-bit operands
    assign prod      = rem_reg * 32'd52429;
    assign quot      = {3'b000, prod[31:19]};
    assign rmd       = rem_reg - ((quot << 3) + (quot << 1));
    assign conv_done = (rem_reg == 16'd0) || (cnt_reg == CW'(DIGITS));
    assign out_free  = !out_valid_reg || pop;

    assign rsp   = out_reg;
    assign empty = !out_valid_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (i < DIGITS)
            begin
                pin_word[i*SEG_W +: SEG_W] = pat_reg[i] ^ {SEG_W{anode_mask[i]}};
            end
            else
            begin
                pin_word[i*SEG_W +: SEG_W] = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pat_next       = pat_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        cmd_pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    status_next = cmd.status;
                    unique case (cmd.kind)
                        CMD_DIGIT:
                        begin
                            pat_next[cmd.idx] = seg_pattern(cmd.value[3:0]);
                            state_next        = S_EMIT;
                        end
                        CMD_NUMBER:
                        begin
                            rem_next   = cmd.value;
                            cnt_next   = '0;
                            state_next = S_CONV;
                        end
                        CMD_REJECT:
                        begin
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    pat_next[cnt_reg[IW-1:0]] = seg_pattern(rmd[3:0]);
                    rem_next                  = quot;
                    cnt_next                  = cnt_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next.status     = status_reg;
                    out_next.pin_levels = pin_word;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pat_reg       <= pat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

endmodule

[sv/multi_digit_seven_segment_driver.sv]
// Top level of the multi-digit seven-segment driver
//
//   channel   | handshake           | payload
//   ----------+---------------------+---------------------------------
//   request   | push / full         | req: opcode, digit_index, value
//   result    | empty / pop         | rsp: status, pin_levels
//   config    | cfg_valid/cfg_ready | cfg_data: anode_mask
//
// Single-digit and rejected requests go from the queue through S_IDLE and S_EMIT to
// the result register; a number also passes through S_CONV, where the back end's
// divide-by-10 unit produces one decimal digit per cycle. The two-entry command queue
// keeps taking requests while the back end works or a result waits. Reset clears all
// digit patterns (segments off) and the anode mask. Config is always ready.
`include "multi_digit_seven_segment_driver_assert.svh"

module multi_digit_seven_segment_driver #(
    parameter int DIGITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  mdss_pkg::mdss_req_t             req,
    output logic                            empty,
    input  logic                            pop,
    output mdss_pkg::mdss_rsp_t             rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mdss_pkg::MAX_DIGITS-1:0] cfg_data
);
    import mdss_pkg::*;

    logic [MAX_DIGITS-1:0] anode_mask_reg, anode_mask_next;
    logic                  enq;
    mdss_cmd_t             enq_cmd;
    mdss_cmd_t             head_cmd;
    logic                  q_full;
    logic                  q_empty;
    logic                  cmd_pop;

    assign cfg_ready       = 1'b1;
    assign anode_mask_next = (cfg_valid && cfg_ready) ? cfg_data : anode_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_mask_reg <= '0;
        end
        else
        begin
            anode_mask_reg <= anode_mask_next;
        end
    end

    mdss_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .push   (push),
        .full   (full),
        .req    (req),
        .q_full (q_full),
        .enq    (enq),
        .cmd    (enq_cmd)
    );

    mdss_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_data (enq_cmd),
        .full    (q_full),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    mdss_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .cmd_valid  (!q_empty),
        .cmd_pop    (cmd_pop),
        .anode_mask (anode_mask_reg),
        .rsp        (rsp),
        .empty      (empty),
        .pop        (pop)
    );

    `MDSS_ASSERT_NEXT(a_accept_queued, push && !full, !q_empty)
    `MDSS_ASSERT_NOW(a_status_code, empty || rsp.status <= ST_RANGE)
    `MDSS_ASSERT_NEXT(a_cfg_taken, cfg_valid && cfg_ready, anode_mask_reg == $past(cfg_data))

endmodule
